/* rtl/ptes_pkg.sv */
// ptes_pkg: payload types, opcodes and sequencer states for the task/event scheduler.
// No dependencies.
package ptes_pkg;

   typedef enum logic [3:0] {
      OP_CLEAR_ALL   = 4'd0,
      OP_PUSH_ACTIVE = 4'd1,
      OP_POP_ACTIVE  = 4'd2,
      OP_ENQUEUE     = 4'd3,
      OP_RESET_EV    = 4'd4,
      OP_WAITING     = 4'd5,
      OP_SUSPENDED   = 4'd6,
      OP_SET_EVENT   = 4'd7,
      OP_CLEAR_EV    = 4'd8,
      OP_READ_EV     = 4'd9,
      OP_WAIT_CUR    = 4'd10,
      OP_PEEK_BEST   = 4'd11,
      OP_HIGHER      = 4'd12,
      OP_POP_BEST    = 4'd13,
      OP_NOP14       = 4'd14,
      OP_NOP15       = 4'd15
   } op_type;

   typedef struct packed {
      logic [3:0]  operation;
      logic [3:0]  task_number;
      logic [7:0]  task_priority;
      logic        task_is_extended;
      logic [63:0] task_allowed_events;
      logic [63:0] event_argument;
      logic [7:0]  compare_priority;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [3:0]  out_task_number;
      logic [7:0]  out_priority;
      logic        out_extended;
      logic [63:0] out_allowed_events;
      logic [63:0] out_events;
      logic        has_active;
      logic [3:0]  current_task_number;
      logic        ready_empty;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type      op;
      logic        id_ok;
      req_type     req;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_SHIFT,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage

/* rtl/priority_task_event_scheduler.sv */
// Task/event scheduler. For each request a sequencer scans ready list and active
// stack one entry a cycle for suspended checks and best-ready search, then executes;
// pop best then moves each ready entry behind the best entry up one place; clear all
// skips the scan and sweeps the event tables instead.
// Depends on ptes_pkg, ptes_front, ptes_back.
module priority_task_event_scheduler import ptes_pkg::*; #(
   parameter int TASK_COUNT  = 16,
   parameter int READY_DEPTH = 16,
   parameter int STACK_DEPTH = 8,
   parameter int EVENT_BITS  = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   ptes_front #(.TASK_COUNT(TASK_COUNT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   ptes_back #(
      .TASK_COUNT(TASK_COUNT), .READY_DEPTH(READY_DEPTH),
      .STACK_DEPTH(STACK_DEPTH), .EVENT_BITS(EVENT_BITS)
   ) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

/* rtl/ptes_front.sv */
// ptes_front: accepts request words, classifies them and queues commands.
// Depends on ptes_pkg.
module ptes_front import ptes_pkg::*; #(
   parameter int TASK_COUNT = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);
   // two-entry queue
   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      q_in.op    = op_type'(req_data.operation);
      q_in.id_ok = ({28'd0, req_data.task_number} < TASK_COUNT);
      q_in.req   = req_data;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) q_ff[wr_ff] <= q_in;
   end
endmodule

/* rtl/ptes_back.sv */
// ptes_back: executes scheduler commands on the task table, ready list and stack.
// Depends on ptes_pkg.
module ptes_back import ptes_pkg::*; #(
   parameter int TASK_COUNT  = 16,
   parameter int READY_DEPTH = 16,
   parameter int STACK_DEPTH = 8,
   parameter int EVENT_BITS  = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int RW = $clog2(READY_DEPTH);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SCW = $clog2(READY_DEPTH + STACK_DEPTH + 1);
   localparam logic [63:0] EV_MASK = {64{1'b1}} >> (64 - EVENT_BITS);

   typedef struct packed {
      logic [3:0]  id;
      logic [7:0]  prio;
      logic        ext;
      logic [63:0] mask;
   } trec_type;

   // per-task storage, ready list and active stack
   logic [TASK_COUNT-1:0] kvalid_ff;
   logic [TASK_COUNT-1:0] wait_ff;
   trec_type    known_ff  [TASK_COUNT];
   logic [63:0] evset_ff  [TASK_COUNT];
   logic [63:0] evwait_ff [TASK_COUNT];
   trec_type    ready_ff  [READY_DEPTH];
   trec_type    stack_ff  [STACK_DEPTH];
   logic [RW:0] rcount_ff;
   logic [SW:0] sdepth_ff;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff;
   logic [SCW-1:0] idx_ff, idx_in;
   logic        found_ff, found_in;    // id found in list/stack, or higher-prio seen
   logic [RW-1:0] best_ff, best_in;
   logic [TW-1:0] clr_ff, clr_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rv_ff;

   logic [TW-1:0] tid;
   logic [63:0] arg, rmask;
   trec_type    newrec, top, kr, re, se;
   logic [SW-1:0] topi;
   logic        susp;

   assign cmd_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   assign tid   = cmd_ff.req.task_number[TW-1:0];
   assign arg   = cmd_ff.req.event_argument & EV_MASK;
   assign rmask = cmd_ff.req.task_allowed_events & EV_MASK;
   assign newrec = '{id: cmd_ff.req.task_number, prio: cmd_ff.req.task_priority,
                     ext: cmd_ff.req.task_is_extended, mask: rmask};
   assign topi  = SW'(sdepth_ff - 1'b1);
   assign top   = stack_ff[topi];
   assign kr    = known_ff[tid];
   assign susp  = !wait_ff[tid] && !found_ff;
   assign re    = ready_ff[idx_ff[RW-1:0]];
   assign se    = stack_ff[SW'(idx_ff - SCW'(READY_DEPTH))];

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   logic ex_valid;
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      best_in  = best_ff;
      clr_in   = clr_ff;
      ex_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               idx_in   = '0;
               found_in = 1'b0;
               best_in  = '0;
               clr_in   = '0;
               state_in = (cmd_data.op == OP_CLEAR_ALL) ? ST_CLEAR : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // ready entries first, then stack entries
            if (idx_ff < SCW'(READY_DEPTH)) begin
               if ({{(SCW-RW-1){1'b0}}, rcount_ff} > idx_ff) begin
                  if (cmd_ff.op == OP_HIGHER) begin
                     if (re.prio > cmd_ff.req.compare_priority) found_in = 1'b1;
                  end else if (re.id == cmd_ff.req.task_number) begin
                     found_in = 1'b1;
                  end
                  if (re.prio > ready_ff[best_ff].prio) best_in = idx_ff[RW-1:0];
               end
            end else if ({{(SCW-SW-1){1'b0}}, sdepth_ff} > idx_ff - SCW'(READY_DEPTH)) begin
               if (se.id == cmd_ff.req.task_number && cmd_ff.op != OP_HIGHER)
                  found_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SCW'(READY_DEPTH + STACK_DEPTH - 1)) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            ex_valid = 1'b1;
            idx_in   = {{(SCW-RW){1'b0}}, best_ff};
            state_in = (cmd_ff.op == OP_POP_BEST && rcount_ff != '0) ? ST_SHIFT : ST_DONE;
         end
         ST_SHIFT: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 >= {{(SCW-RW-1){1'b0}}, rcount_ff}) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if ({{(32-TW){1'b0}}, clr_ff} == TASK_COUNT - 1) state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result word
   always_comb begin
      rsp_in = '0;
      unique case (cmd_ff.op)
         OP_CLEAR_ALL: rsp_in.success = 1'b1;
         OP_PUSH_ACTIVE: rsp_in.success = cmd_ff.id_ok &&
                                           ({{(31-SW){1'b0}}, sdepth_ff} < STACK_DEPTH);
         OP_POP_ACTIVE: rsp_in.success = (sdepth_ff != '0);
         OP_ENQUEUE: rsp_in.success = cmd_ff.id_ok &&
                                       ({{(31-RW){1'b0}}, rcount_ff} < READY_DEPTH);
         OP_RESET_EV: rsp_in.success = cmd_ff.id_ok && kvalid_ff[tid];
         OP_WAITING: rsp_in.success = cmd_ff.id_ok && wait_ff[tid];
         OP_SUSPENDED: rsp_in.success = cmd_ff.id_ok && susp;
         OP_SET_EVENT: rsp_in.success = cmd_ff.id_ok && kvalid_ff[tid] && kr.ext && !susp
            && ((arg & kr.mask) != '0) && wait_ff[tid] && (evwait_ff[tid] != '0)
            && (((evset_ff[tid] | (arg & kr.mask)) & evwait_ff[tid]) != '0)
            && ({{(31-RW){1'b0}}, rcount_ff} < READY_DEPTH);
         OP_CLEAR_EV: rsp_in.success = (sdepth_ff != '0) && top.ext &&
                                        ({28'd0, top.id} < TASK_COUNT);
         OP_READ_EV: begin
            rsp_in.success = cmd_ff.id_ok && kvalid_ff[tid] && kr.ext && !susp;
            rsp_in.out_events = rsp_in.success ? evset_ff[tid] : '0;
         end
         OP_WAIT_CUR: rsp_in.success = (sdepth_ff != '0) && top.ext &&
            ({28'd0, top.id} < TASK_COUNT) && ((arg & top.mask) != '0) &&
            ((evset_ff[top.id[TW-1:0]] & arg & top.mask) == '0);
         OP_PEEK_BEST, OP_POP_BEST: begin
            rsp_in.success = (rcount_ff != '0);
            if (rcount_ff != '0) begin
               rsp_in.out_task_number    = ready_ff[best_ff].id;
               rsp_in.out_priority       = ready_ff[best_ff].prio;
               rsp_in.out_extended       = ready_ff[best_ff].ext;
               rsp_in.out_allowed_events = ready_ff[best_ff].mask;
            end
         end
         OP_HIGHER: rsp_in.success = found_ff;
         default: rsp_in.success = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff     <= 1'b0;
         kvalid_ff <= '0;
         wait_ff   <= '0;
         rcount_ff <= '0;
         sdepth_ff <= '0;
         idx_ff    <= '0;
         found_ff  <= 1'b0;
         best_ff   <= '0;
         clr_ff    <= '0;
         for (int i = 0; i < TASK_COUNT; i++) begin
            evset_ff[i]  <= '0;
            evwait_ff[i] <= '0;
         end
      end else begin
         idx_ff   <= idx_in;
         found_ff <= found_in;
         best_ff  <= best_in;
         clr_ff   <= clr_in;
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         if (state_ff == ST_IDLE && cmd_valid && cmd_ready) begin
            cmd_ff <= cmd_data;
            if (cmd_data.op == OP_CLEAR_ALL) begin
               kvalid_ff <= '0;
               wait_ff   <= '0;
               rcount_ff <= '0;
               sdepth_ff <= '0;
            end
         end
         if (state_ff == ST_CLEAR) begin
            evset_ff[clr_ff]  <= '0;
            evwait_ff[clr_ff] <= '0;
         end
         if (state_ff == ST_SHIFT) begin
            if (idx_ff + 1'b1 < {{(SCW-RW-1){1'b0}}, rcount_ff})
               ready_ff[idx_ff[RW-1:0]] <= ready_ff[RW'(idx_ff + 1'b1)];
            else
               rcount_ff <= rcount_ff - 1'b1;
         end
         if (state_ff == ST_DONE) begin
            rv_ff  <= 1'b1;
            rsp_ff.has_active <= (sdepth_ff != '0);
            rsp_ff.current_task_number <= (sdepth_ff != '0) ? top.id : 4'd0;
            rsp_ff.ready_empty <= (rcount_ff == '0);
            if (cmd_ff.op == OP_CLEAR_ALL) begin
               rsp_ff.success             <= 1'b1;
               rsp_ff.out_task_number     <= '0;
               rsp_ff.out_priority        <= '0;
               rsp_ff.out_extended        <= 1'b0;
               rsp_ff.out_allowed_events  <= '0;
               rsp_ff.out_events          <= '0;
            end
         end
         if (ex_valid) begin
            rsp_ff.success            <= rsp_in.success;
            rsp_ff.out_task_number    <= rsp_in.out_task_number;
            rsp_ff.out_priority       <= rsp_in.out_priority;
            rsp_ff.out_extended       <= rsp_in.out_extended;
            rsp_ff.out_allowed_events <= rsp_in.out_allowed_events;
            rsp_ff.out_events         <= rsp_in.out_events;
            unique case (cmd_ff.op)
               OP_PUSH_ACTIVE: if (rsp_in.success) begin
                  kvalid_ff[tid] <= 1'b1;
                  known_ff[tid]  <= newrec;
                  wait_ff[tid]   <= 1'b0;
                  stack_ff[SW'(sdepth_ff)] <= newrec;
                  sdepth_ff <= sdepth_ff + 1'b1;
               end
               OP_POP_ACTIVE: if (rsp_in.success) sdepth_ff <= sdepth_ff - 1'b1;
               OP_ENQUEUE: if (rsp_in.success) begin
                  kvalid_ff[tid] <= 1'b1;
                  known_ff[tid]  <= newrec;
                  wait_ff[tid]   <= 1'b0;
                  ready_ff[RW'(rcount_ff)] <= newrec;
                  rcount_ff <= rcount_ff + 1'b1;
               end
               OP_RESET_EV: if (rsp_in.success) begin
                  evset_ff[tid]  <= '0;
                  evwait_ff[tid] <= '0;
                  wait_ff[tid]   <= 1'b0;
               end
               OP_SET_EVENT: begin
                  if (cmd_ff.id_ok && kvalid_ff[tid] && kr.ext && !susp)
                     evset_ff[tid] <= evset_ff[tid] | (arg & kr.mask);
                  if (rsp_in.success) begin
                     evwait_ff[tid] <= '0;
                     wait_ff[tid]   <= 1'b0;
                     ready_ff[RW'(rcount_ff)] <= kr;
                     rcount_ff <= rcount_ff + 1'b1;
                  end
               end
               OP_CLEAR_EV: if (rsp_in.success)
                  evset_ff[top.id[TW-1:0]] <= evset_ff[top.id[TW-1:0]] & ~(arg & top.mask);
               OP_WAIT_CUR: if (rsp_in.success) begin
                  evwait_ff[top.id[TW-1:0]] <= arg & top.mask;
                  wait_ff[top.id[TW-1:0]]   <= 1'b1;
                  sdepth_ff <= sdepth_ff - 1'b1;
               end
               default: ;
            endcase
         end
      end
   end
endmodule
